>>> src/vnd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnd_pkg: shared types and constants for the vector norm and dot reducer
// Holds the mode codes, sequencer states, datapath widths and the control
// bundle that the sequencer drives into the reduction datapath.
// ----------------------------------------------------------------------------
package vnd_pkg;

   localparam int MAX_LENGTH_DEF = 1024;
   localparam int ELEM_WIDTH_DEF = 32;

   localparam int FIELD_W = 32;                // element field width on the port
   localparam int OPND_W  = FIELD_W + 1;       // signed operand, holds |min|
   localparam int PROD_W  = 2 * OPND_W;
   localparam int MAG_W   = FIELD_W;
   localparam int ACC_W   = 80;
   localparam int RES_W   = 64;
   localparam int ROOT_W  = ACC_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int DOT_SHIFT = 16;

   localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << (DOT_SHIFT - 1);
   localparam logic [RES_W-1:0] SAT_MAX   = {1'b0, {(RES_W-1){1'b1}}};
   localparam logic [RES_W-1:0] SAT_MIN   = {1'b1, {(RES_W-1){1'b0}}};

   typedef enum logic [1:0] {
      MODE_L1  = 2'd0,
      MODE_L2  = 2'd1,
      MODE_INF = 2'd2,
      MODE_DOT = 2'd3
   } vnd_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_ROUND,
      S_SQRT,
      S_SQRT_WAIT,
      S_DONE
   } vnd_state_type;

   typedef struct packed {
      logic load;    // capture a new element pair
      logic clear;   // start of a vector: zero the sum and the maximum
      logic mul;     // register the product term
      logic acc;     // add the term, update the maximum
      logic round;   // add the half-LSB for the dot result
   } vnd_mac_ctl_type;

endpackage
`default_nettype wire

>>> src/vnd_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnd_mac: shared multiply and accumulate datapath
// One signed multiplier and one 80-bit adder, stepped by the sequencer;
// also tracks the running maximum magnitude for the infinity norm.
// ----------------------------------------------------------------------------
module vnd_mac #(
   parameter int ELEM_WIDTH = vnd_pkg::ELEM_WIDTH_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  vnd_pkg::vnd_mac_ctl_type        ctl,
   input  vnd_pkg::vnd_mode_type           mode,
   input  wire [vnd_pkg::FIELD_W-1:0]      elem_a,
   input  wire [vnd_pkg::FIELD_W-1:0]      elem_b,
   output logic [vnd_pkg::ACC_W-1:0]       acc_sum,
   output logic [vnd_pkg::MAG_W-1:0]       max_mag
);

   localparam int EXT_W = vnd_pkg::OPND_W - ELEM_WIDTH;

   logic signed [vnd_pkg::OPND_W-1:0] a_ff, b_ff, a_in, b_in;
   logic signed [vnd_pkg::OPND_W-1:0] mag_full, op_x, op_y;
   logic signed [vnd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic        [vnd_pkg::MAG_W-1:0]  mag_ff;
   logic        [vnd_pkg::ACC_W-1:0]  acc_ff, acc_in, addend;
   logic        [vnd_pkg::MAG_W-1:0]  max_ff, max_in;

   // sign-extend the used low bits of each element
   assign a_in = {{EXT_W{elem_a[ELEM_WIDTH-1]}}, elem_a[ELEM_WIDTH-1:0]};
   assign b_in = {{EXT_W{elem_b[ELEM_WIDTH-1]}}, elem_b[ELEM_WIDTH-1:0]};

   assign mag_full = a_ff[vnd_pkg::OPND_W-1] ? -a_ff : a_ff;

   always_comb begin
      unique case (mode)
         vnd_pkg::MODE_L2: begin
            op_x = mag_full;
            op_y = mag_full;
         end
         vnd_pkg::MODE_DOT: begin
            op_x = a_ff;
            op_y = b_ff;
         end
         default: begin
            op_x = mag_full;
            op_y = vnd_pkg::OPND_W'(1);
         end
      endcase
   end

   assign prod_in = op_x * op_y;

   // one adder serves both the element sum and the closing round step
   assign addend = ctl.round ? vnd_pkg::ROUND_ADD
                             : {{(vnd_pkg::ACC_W-vnd_pkg::PROD_W){prod_ff[vnd_pkg::PROD_W-1]}},
                                prod_ff};

   always_comb begin
      acc_in = acc_ff;
      max_in = max_ff;
      if (ctl.clear) begin
         acc_in = '0;
         max_in = '0;
      end else if (ctl.acc || ctl.round) begin
         acc_in = acc_ff + addend;
         if (ctl.acc && mode == vnd_pkg::MODE_INF && mag_ff > max_ff) begin
            max_in = mag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         max_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         max_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (ctl.mul) begin
         prod_ff <= prod_in;
         mag_ff  <= mag_full[vnd_pkg::MAG_W-1:0];
      end
   end

   assign acc_sum = acc_ff;
   assign max_mag = max_ff;

endmodule
`default_nettype wire

>>> src/vnd_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnd_isqrt: iterative integer square root
// Digit-by-digit root of an 80-bit radicand, one root bit per cycle through
// a single compare and subtract; floor of the exact root.
// ----------------------------------------------------------------------------
module vnd_isqrt (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire [vnd_pkg::ACC_W-1:0]       radicand,
   output logic                           done,
   output logic [vnd_pkg::ROOT_W-1:0]     root
);

   localparam int CNT_W = $clog2(vnd_pkg::ROOT_W);
   localparam int SH_W  = vnd_pkg::REM_W + 2;

   logic [vnd_pkg::ACC_W-1:0]  rad_ff, rad_in;
   logic [vnd_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [vnd_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [SH_W-1:0]            shifted, trial, diff;

   assign shifted = {rem_ff, rad_ff[vnd_pkg::ACC_W-1 -: 2]};
   assign trial   = SH_W'({root_ff, 2'b01});
   assign diff    = shifted - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(vnd_pkg::ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (shifted >= trial) begin
            rem_in  = diff[vnd_pkg::REM_W-1:0];
            root_in = {root_ff[vnd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[vnd_pkg::REM_W-1:0];
            root_in = {root_ff[vnd_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

>>> src/vector_norm_and_dot_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_norm_and_dot_reduce: streaming L1 / L2 / infinity norm and dot product
// Reduces a vector, one element per transfer, to one Q47.16 result, saturated in L1 mode.
// ----------------------------------------------------------------------------
//   channel  direction  tdata                          tuser        tlast
//   req_     in         [31:0] elem_a, [63:32] elem_b  [1:0] func   last
//   rsp_     out        [63:0] norm_value              [0] saturated  -
//
// Each element is captured, multiplied and accumulated in the shared
// multiply-accumulate unit before the next one is taken; the closing element
// adds a round step on the same adder for dot, and for L2 the square root,
// which resolves one bit per cycle. Synchronous active-high reset; the
// result sits in an output register, so a stalled rsp_ side holds the block
// only when a second vector closes before the first result is taken.
// ----------------------------------------------------------------------------
module vector_norm_and_dot_reduce #(
   parameter int MAX_LENGTH = vnd_pkg::MAX_LENGTH_DEF,
   parameter int ELEM_WIDTH = vnd_pkg::ELEM_WIDTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [31:0] elem_a, [63:32] elem_b
   input  wire  [1:0]  req_tuser,   // [1:0] func
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] norm_value
   output logic [0:0]  rsp_tuser    // [0] saturated
);

   localparam int CNT_W = $clog2(MAX_LENGTH + 1);

   vnd_pkg::vnd_state_type   state_ff, state_in;
   vnd_pkg::vnd_mode_type    mode_ff, mode_in;
   vnd_pkg::vnd_mac_ctl_type ctl;
   logic                     first_ff, first_in;
   logic                     closing_ff, closing_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in, cnt_next;
   logic                     accept;
   logic                     sqrt_start, sqrt_done;
   logic [vnd_pkg::ROOT_W-1:0] root;
   logic [vnd_pkg::ACC_W-1:0]  acc_sum;
   logic [vnd_pkg::MAG_W-1:0]  max_mag;
   logic                     out_load;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [vnd_pkg::RES_W-1:0] rsp_data_ff, res_value;
   logic                     rsp_sat_ff, res_sat;

   assign req_tready = (state_ff == vnd_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign cnt_next   = (first_ff ? '0 : cnt_ff) + CNT_W'(1);
   assign closing_in = req_tlast || (cnt_next >= CNT_W'(MAX_LENGTH));
   assign mode_in    = first_ff ? vnd_pkg::vnd_mode_type'(req_tuser) : mode_ff;
   assign cnt_in     = cnt_next;

   always_comb begin
      state_in   = state_ff;
      first_in   = first_ff;
      ctl        = '0;
      sqrt_start = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         vnd_pkg::S_IDLE: begin
            if (accept) begin
               ctl.load  = 1'b1;
               ctl.clear = first_ff;
               first_in  = 1'b0;
               state_in  = vnd_pkg::S_MUL;
            end
         end
         vnd_pkg::S_MUL: begin
            ctl.mul  = 1'b1;
            state_in = vnd_pkg::S_ACC;
         end
         vnd_pkg::S_ACC: begin
            ctl.acc = 1'b1;
            if (closing_ff) begin
               first_in = 1'b1;
               if (mode_ff == vnd_pkg::MODE_L2) begin
                  state_in = vnd_pkg::S_SQRT;
               end else if (mode_ff == vnd_pkg::MODE_DOT) begin
                  state_in = vnd_pkg::S_ROUND;
               end else begin
                  state_in = vnd_pkg::S_DONE;
               end
            end else begin
               state_in = vnd_pkg::S_IDLE;
            end
         end
         vnd_pkg::S_ROUND: begin
            ctl.round = 1'b1;
            state_in  = vnd_pkg::S_DONE;
         end
         vnd_pkg::S_SQRT: begin
            sqrt_start = 1'b1;
            state_in   = vnd_pkg::S_SQRT_WAIT;
         end
         vnd_pkg::S_SQRT_WAIT: begin
            if (sqrt_done) begin
               state_in = vnd_pkg::S_DONE;
            end
         end
         vnd_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = vnd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = vnd_pkg::S_IDLE;
         end
      endcase
   end

   // result select; the L1 sum is clipped to the 64-bit signed range
   always_comb begin
      res_sat = 1'b0;
      unique case (mode_ff)
         vnd_pkg::MODE_L1: begin
            if (acc_sum[vnd_pkg::ACC_W-1:vnd_pkg::RES_W] ==
                {(vnd_pkg::ACC_W-vnd_pkg::RES_W){acc_sum[vnd_pkg::RES_W-1]}}) begin
               res_value = acc_sum[vnd_pkg::RES_W-1:0];
            end else begin
               res_sat   = 1'b1;
               res_value = acc_sum[vnd_pkg::ACC_W-1] ? vnd_pkg::SAT_MIN : vnd_pkg::SAT_MAX;
            end
         end
         vnd_pkg::MODE_L2:  res_value = vnd_pkg::RES_W'(root);
         vnd_pkg::MODE_INF: res_value = vnd_pkg::RES_W'(max_mag);
         vnd_pkg::MODE_DOT:
            res_value = acc_sum[vnd_pkg::DOT_SHIFT +: vnd_pkg::RES_W];
         default: res_value = '0;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vnd_pkg::S_IDLE;
         mode_ff      <= vnd_pkg::MODE_L1;
         first_ff     <= 1'b1;
         cnt_ff       <= '0;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff    <= mode_in;
            cnt_ff     <= cnt_in;
            closing_ff <= closing_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= res_value;
         rsp_sat_ff  <= res_sat;
      end
   end

   vnd_mac #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .mode    (mode_ff),
      .elem_a  (req_tdata[31:0]),
      .elem_b  (req_tdata[63:32]),
      .acc_sum (acc_sum),
      .max_mag (max_mag)
   );

   vnd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_sum),
      .done     (sqrt_done),
      .root     (root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule
`default_nettype wire

>>> bench/vector_norm_and_dot_reduce_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_norm_and_dot_reduce_tb: self-checking bench for the norm/dot reducer
// Streams vectors of signed Q15.16 elements in all four modes. It includes
// extreme values, round-half cases of the dot product and a vector long enough
// to close on the length limit. Random gaps are applied to both channels and
// a long hold-off to results. A local model of the reduction predicts each
// Q47.16 result, and every result transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module vector_norm_and_dot_reduce_tb;

   localparam int MAX_LEN   = vnd_pkg::MAX_LENGTH_DEF;
   localparam int ITEMS_ALL = 1150;

   typedef struct {
      logic [1:0]  func;
      logic [31:0] elem_a;
      logic [31:0] elem_b;
      logic        last;
   } element_type;

   typedef struct {
      logic [63:0] norm_value;
      logic        saturated;
   } norm_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] elem_a, [63:32] elem_b
   logic [1:0]  req_tuser = '0;   // [1:0] func
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [63:0] norm_value
   logic [0:0]  rsp_tuser;        // [0] saturated

   element_type     element_queue[$];
   norm_result_type pending_norms[$];
   int              mismatch_count = 0;

   // local copy of the reduction state
   logic [79:0]           sum_acc;
   logic [31:0]           peak_mag;
   vnd_pkg::vnd_mode_type held_mode;
   logic                  at_start;
   logic [16:0]           elem_count;

   vector_norm_and_dot_reduce u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int pick_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] pick_elem();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0001_0000;
         5, 6: return 32'($urandom_range(0, 32'h3_ffff)) - 32'h2_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [39:0] root_floor(logic [79:0] radicand);
      logic [47:0] rem;
      logic [47:0] trial;
      logic [39:0] root;
      rem  = '0;
      root = '0;
      for (int k = 39; k >= 0; k--) begin
         rem   = {rem[45:0], radicand[2*k +: 2]};
         trial = {6'd0, root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[38:0], 1'b1};
         end else begin
            root = {root[38:0], 1'b0};
         end
      end
      return root;
   endfunction

   task automatic add_element(logic [1:0] func, logic [31:0] a, logic [31:0] b, logic last);
      element_type e;
      e.func   = func;
      e.elem_a = a;
      e.elem_b = b;
      e.last   = last;
      element_queue = {element_queue, e};
   endtask

   // fold one accepted element into the running reduction
   task automatic reduce_element(logic [1:0] func, logic [31:0] a_raw, logic [31:0] b_raw,
                                 logic last);
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] prod;
      logic [31:0]        mag;
      logic [79:0]        wide;
      logic signed [79:0] rounded;
      norm_result_type    res;
      a   = {{32{a_raw[31]}}, a_raw};
      b   = {{32{b_raw[31]}}, b_raw};
      mag = a_raw[31] ? 32'(-a) : a_raw;
      if (at_start) begin
         held_mode  = vnd_pkg::vnd_mode_type'(func);
         sum_acc    = '0;
         peak_mag   = '0;
         elem_count = '0;
         at_start   = 1'b0;
      end
      elem_count = elem_count + 17'd1;
      case (held_mode)
         vnd_pkg::MODE_L1:  sum_acc = sum_acc + {48'd0, mag};
         vnd_pkg::MODE_L2:  sum_acc = sum_acc + {16'd0, 64'(mag) * 64'(mag)};
         vnd_pkg::MODE_INF: if (mag > peak_mag) peak_mag = mag;
         default: begin
            prod    = a * b;
            sum_acc = sum_acc + {{16{prod[63]}}, prod};
         end
      endcase
      if (!last && elem_count < MAX_LEN) return;
      at_start = 1'b1;
      case (held_mode)
         vnd_pkg::MODE_L1:  wide = sum_acc;
         vnd_pkg::MODE_L2:  wide = {40'd0, root_floor(sum_acc)};
         vnd_pkg::MODE_INF: wide = {48'd0, peak_mag};
         default: begin
            rounded = $signed(sum_acc + vnd_pkg::ROUND_ADD);
            wide    = rounded >>> vnd_pkg::DOT_SHIFT;
         end
      endcase
      if (wide[79:64] == {16{wide[63]}}) begin
         res.norm_value = wide[63:0];
         res.saturated  = 1'b0;
      end else begin
         res.norm_value = wide[79] ? vnd_pkg::SAT_MIN : vnd_pkg::SAT_MAX;
         res.saturated  = 1'b1;
      end
      pending_norms = {pending_norms, res};
   endtask

   // sender: hold each element until its transfer, then idle for a while
   int          send_gap = 0;
   int          send_calm = 0;
   element_type send_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (element_queue.size() != 0) begin
            send_item = element_queue.pop_front();
            req_tdata  <= {send_item.elem_b, send_item.elem_a};
            req_tuser  <= send_item.func;
            req_tlast  <= send_item.last;
            req_tvalid <= 1'b1;
            send_gap = pick_idle(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure plus one long hold-off
   int take_gap = 0;
   int take_calm = 0;
   int taken = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            taken++;
            take_gap = pick_idle(take_calm);
            // hold long enough for the block to back up into its input
            if (taken == 40) take_gap = 400;
         end else if (take_gap == 0 && $urandom_range(0, 15) == 0) begin
            take_gap = pick_idle(take_calm);
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: check results first, then predict from the input transfer
   norm_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         sum_acc    = '0;
         peak_mag   = '0;
         held_mode  = vnd_pkg::MODE_L1;
         at_start   = 1'b1;
         elem_count = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_norms.size() == 0) begin
               $display("%0t: result with none expected: norm_value %h saturated %b",
                        $time, rsp_tdata, rsp_tuser[0]);
               mismatch_count++;
            end else begin
               want = pending_norms.pop_front();
               if (rsp_tdata !== want.norm_value) begin
                  $display("%0t: bad norm_value: expected %h actual %h",
                           $time, want.norm_value, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== want.saturated) begin
                  $display("%0t: bad saturated: expected %b actual %b",
                           $time, want.saturated, rsp_tuser[0]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            reduce_element(req_tuser, req_tdata[31:0], req_tdata[63:32], req_tlast);
      end
   end

   initial begin
      int          len;
      int          r;
      logic [1:0]  mode;

      // single-element extremes
      add_element(vnd_pkg::MODE_L1, 32'h8000_0000, $urandom(), 1'b1);
      add_element(vnd_pkg::MODE_L1, 32'h7fff_ffff, $urandom(), 1'b1);
      add_element(vnd_pkg::MODE_L1, 32'h0000_0000, 32'hffff_ffff, 1'b1);
      add_element(vnd_pkg::MODE_L2, 32'h8000_0000, 32'h0, 1'b1);
      // root of two in Q15.16, truncated
      add_element(vnd_pkg::MODE_L2, 32'h0001_0000, 32'h0, 1'b0);
      add_element(vnd_pkg::MODE_INF, 32'h0001_0000, 32'h0, 1'b1);
      // func on later elements must be ignored
      add_element(vnd_pkg::MODE_INF, 32'hffff_fffb, 32'h0, 1'b0);
      add_element(vnd_pkg::MODE_L1, 32'h7fff_ffff, 32'h0, 1'b0);
      add_element(vnd_pkg::MODE_DOT, 32'h8000_0000, 32'h0, 1'b1);
      add_element(vnd_pkg::MODE_DOT, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_element(vnd_pkg::MODE_L2, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
      add_element(vnd_pkg::MODE_INF, 32'hffff_ffff, 32'h0000_0001, 1'b1);
      // dot rounding: exactly half rounds up on both signs
      add_element(vnd_pkg::MODE_DOT, 32'h0000_0001, 32'h0000_8000, 1'b1);
      add_element(vnd_pkg::MODE_DOT, 32'hffff_ffff, 32'h0000_8000, 1'b1);
      add_element(vnd_pkg::MODE_DOT, 32'hffff_ffff, 32'h0000_7fff, 1'b1);
      add_element(vnd_pkg::MODE_DOT, 32'h0000_0001, 32'h0000_7fff, 1'b1);
      // elem_b has no effect outside dot mode
      add_element(vnd_pkg::MODE_L2, 32'h0003_0000, 32'hdead_beef, 1'b0);
      add_element(vnd_pkg::MODE_DOT, 32'h0004_0000, 32'h1234_5678, 1'b1);

      // overlong vector: closes on the length limit with last never set
      for (int i = 0; i < MAX_LEN; i++)
         add_element((i == 0) ? vnd_pkg::MODE_DOT : 2'($urandom_range(0, 3)),
                     (i % 4 == 3) ? pick_elem() : 32'h8000_0000,
                     (i % 4 == 3) ? pick_elem() : 32'h8000_0000, 1'b0);

      // random vectors up to the item budget
      while (element_queue.size() < ITEMS_ALL) begin
         mode = 2'($urandom_range(0, 3));
         r    = $urandom_range(0, 9);
         len  = (r < 7) ? $urandom_range(1, 6) :
                (r < 9) ? $urandom_range(7, 30) : $urandom_range(31, 120);
         if (len > ITEMS_ALL - element_queue.size())
            len = ITEMS_ALL - element_queue.size();
         for (int i = 0; i < len; i++)
            add_element((i == 0) ? mode : 2'($urandom_range(0, 3)), pick_elem(), pick_elem(),
                        i == len - 1);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (element_queue.size() == 0);
      @(posedge clock);
      while (req_tvalid) @(posedge clock);
      while (pending_norms.size() != 0) @(posedge clock);
      // the square root is the slowest closing step
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
